[design/cifa_pkg.sv]
// ----------------------------------------------------------------------------
// cifa_pkg: shared types and constants
// Fixed-point constants and the request type used between the sequencer
// and the shared multiply and divide units.
// ----------------------------------------------------------------------------
`default_nettype none

package cifa_pkg;

  localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
  localparam logic [63:0] MAX_U64   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAX_S64   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_S64   = 64'h8000_0000_0000_0000;

  // Configuration register indexes
  localparam logic [1:0] REG_MAX_VELOCITY = 2'd0;
  localparam logic [1:0] REG_MICHAELIS    = 2'd1;
  localparam logic [1:0] REG_INHIBITION   = 2'd2;

  // Operation request to a shared unit
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } op_req_t;

endpackage

`default_nettype wire

[design/cifa_if.sv]
// ----------------------------------------------------------------------------
// cifa_if: channel interfaces
// Design-point input channel and information-matrix result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface cifa_point_if;
  logic        valid;
  logic        ready;
  logic [31:0] substrate;
  logic [31:0] inhibitor;
  logic [16:0] weight;
  logic        last_point;
  modport source (output valid, substrate, inhibitor, weight, last_point, input ready);
  modport sink   (input valid, substrate, inhibitor, weight, last_point, output ready);
endinterface

interface cifa_info_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] entry_vv;
  logic signed [63:0] entry_vk;
  logic signed [63:0] entry_vi;
  logic signed [63:0] entry_kk;
  logic signed [63:0] entry_ki;
  logic signed [63:0] entry_ii;
  logic               saturated;
  modport source (output valid, entry_vv, entry_vk, entry_vi, entry_kk, entry_ki,
                  entry_ii, saturated, input ready);
  modport sink   (input valid, entry_vv, entry_vk, entry_vi, entry_kk, entry_ki,
                  entry_ii, saturated, output ready);
endinterface

`default_nettype wire

[design/cifa_mul.sv]
// ----------------------------------------------------------------------------
// cifa_mul: iterative 64x64 multiplier
// Full 128-bit product built from four 32x32 partial products, one a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cifa_mul (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cifa_pkg::op_req_t req,
  output logic                 done,
  output logic [127:0]         prod
);

  logic [63:0]  a;
  logic [63:0]  b;
  logic [1:0]   step;
  logic         busy;
  logic [31:0]  a_part;
  logic [31:0]  b_part;
  logic [63:0]  pp;
  logic [127:0] pp_shifted;

  // Select the partial product of this step and align it
  always_comb begin
    a_part = step[1] ? a[63:32] : a[31:0];
    b_part = step[0] ? b[63:32] : b[31:0];
    pp     = 64'(a_part) * 64'(b_part);
    case ({1'b0, step[1]} + {1'b0, step[0]})
      2'd0:    pp_shifted = {64'b0, pp};
      2'd1:    pp_shifted = {32'b0, pp, 32'b0};
      2'd2:    pp_shifted = {pp, 64'b0};
      default: pp_shifted = 128'b0;
    endcase
  end

  // Accumulate partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= !req.start && busy && (step == 2'd3);
      if (req.start) begin
        a    <= req.a;
        b    <= req.b;
        prod <= 128'b0;
        step <= 2'd0;
        busy <= 1'b1;
      end else if (busy) begin
        prod <= prod + pp_shifted;
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

[design/cifa_div.sv]
// ----------------------------------------------------------------------------
// cifa_div: radix-2 fixed-point divider
// Computes floor(a * 2^32 / b) one quotient bit a cycle, saturating.
// ----------------------------------------------------------------------------
`default_nettype none

module cifa_div (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cifa_pkg::op_req_t req,
  output logic                 done,
  output logic [63:0]          quot,
  output logic                 sat
);

  logic [63:0] rem;
  logic [63:0] num;
  logic [63:0] b;
  logic [5:0]  cnt;
  logic        busy;
  logic [63:0] rem_sh;
  logic        take;
  logic        quick;

  // One restoring step
  always_comb begin
    rem_sh = {rem[62:0], num[63]};
    take   = rem[63] || (rem_sh >= b);
  end

  // Quotient does not fit when the divisor is zero or too small
  assign quick = (req.b == 64'b0) || ({32'b0, req.a[63:32]} >= req.b);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= req.start ? quick : (busy && (cnt == 6'd0));
      if (req.start) begin
        sat <= quick;
        if (quick) begin
          // Saturate at once
          quot <= cifa_pkg::MAX_U64;
        end else begin
          rem  <= {32'b0, req.a[63:32]};
          num  <= {req.a[31:0], 32'b0};
          b    <= req.b;
          quot <= 64'b0;
          cnt  <= 6'd63;
          busy <= 1'b1;
        end
      end else if (busy) begin
        num  <= {num[62:0], 1'b0};
        rem  <= take ? rem_sh - b : rem_sh;
        quot <= {quot[62:0], take};
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

[design/competitive_inhibition_fim_accumulator.sv]
// ----------------------------------------------------------------------------
// competitive_inhibition_fim_accumulator: Fisher information accumulator
// Gradient of the competitive-inhibition rate per weighted design point,
// outer product accumulated into six saturating Q32.32 entries.
// ----------------------------------------------------------------------------
// Per point the sequencer runs four divides and eighteen multiplies on the
// shared units, skipping the gradient ones when the denominator is zero; a
// divide that saturates at once finishes early. Ready only while idle, so a
// new point is not taken before the last one is through.
// A result is held until taken; a second closing point waits for it.
// Reset: synchronous; accumulators and flag cleared, registers set to 1.0.
`default_nettype none

module competitive_inhibition_fim_accumulator #(
  parameter int ACC_FRAC_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  cifa_point_if.sink       point,
  cifa_info_if.source      info
);

  localparam int TERM_SHIFT = 48 - ACC_FRAC_BITS;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_R    = 5'd1;
  localparam logic [4:0] ST_A    = 5'd2;
  localparam logic [4:0] ST_M1   = 5'd3;
  localparam logic [4:0] ST_C    = 5'd4;
  localparam logic [4:0] ST_SV   = 5'd5;
  localparam logic [4:0] ST_CC   = 5'd6;
  localparam logic [4:0] ST_T    = 5'd7;
  localparam logic [4:0] ST_G0   = 5'd8;
  localparam logic [4:0] ST_G1   = 5'd9;
  localparam logic [4:0] ST_KR   = 5'd10;
  localparam logic [4:0] ST_Q    = 5'd11;
  localparam logic [4:0] ST_G2   = 5'd12;
  localparam logic [4:0] ST_P    = 5'd13;
  localparam logic [4:0] ST_W    = 5'd14;
  localparam logic [4:0] ST_ACC  = 5'd15;
  localparam logic [4:0] ST_DONE = 5'd16;

  logic [4:0]  state;
  logic        issued;
  logic [31:0] max_velocity;
  logic [31:0] michaelis_constant;
  logic [31:0] inhibition_constant;
  logic [63:0] s_q;
  logic [63:0] inh_q;
  logic [16:0] weight;
  logic        last_point;
  logic [63:0] r, a, c, t, g0, g1, g2, tmp, cc, p;
  logic [63:0] term;
  logic [2:0]  idx;
  logic        hit;
  logic        saturation_seen;
  logic [63:0] acc [6];

  cifa_pkg::op_req_t mul_req;
  cifa_pkg::op_req_t div_req;
  logic         mul_done;
  logic [127:0] mul_prod;
  logic         div_done;
  logic [63:0]  div_quot;
  logic         div_sat;

  logic [63:0]  v_q, km_q, kic_q;
  logic [63:0]  mulq_res;
  logic         mulq_sat;
  logic [127:0] term_shifted;
  logic [63:0]  term_mag;
  logic         term_sat;
  logic [63:0]  gi, gj;
  logic         neg;
  logic [64:0]  sum_a;
  logic [64:0]  sum_c;
  logic [64:0]  acc_sum;
  logic         acc_ovf;
  logic [63:0]  acc_cur;
  logic         emit;

  cifa_mul u_mul (.clk, .rst, .req(mul_req), .done(mul_done), .prod(mul_prod));
  cifa_div u_div (.clk, .rst, .req(div_req), .done(div_done), .quot(div_quot),
                  .sat(div_sat));

  assign v_q   = {16'b0, max_velocity, 16'b0};
  assign km_q  = {16'b0, michaelis_constant, 16'b0};
  assign kic_q = {16'b0, inhibition_constant, 16'b0};

  assign point.ready = (state == ST_IDLE);

  // Load the result register on a closing point once it is free
  assign emit = (state == ST_DONE) && last_point && (!info.valid || info.ready);

  // Scale product back to Q32.32 with saturation
  assign mulq_sat = |mul_prod[127:96];
  assign mulq_res = mulq_sat ? cifa_pkg::MAX_U64 : mul_prod[95:32];

  // Weighted term magnitude, clipped to the signed range
  always_comb begin
    term_shifted = mul_prod >> TERM_SHIFT;
    term_sat     = |term_shifted[127:64] || term_shifted[63];
    term_mag     = term_sat ? cifa_pkg::MAX_S64 : term_shifted[63:0];
  end

  // Gradient pair and sign for the entry being accumulated
  always_comb begin
    case (idx)
      3'd0:    begin gi = g0; gj = g0; neg = 1'b0; end
      3'd1:    begin gi = g0; gj = g1; neg = 1'b1; end
      3'd2:    begin gi = g0; gj = g2; neg = 1'b0; end
      3'd3:    begin gi = g1; gj = g1; neg = 1'b0; end
      3'd4:    begin gi = g1; gj = g2; neg = 1'b1; end
      default: begin gi = g2; gj = g2; neg = 1'b0; end
    endcase
  end

  // Saturating sums
  always_comb begin
    sum_a   = {1'b0, cifa_pkg::ONE_Q32} + {1'b0, r};
    sum_c   = {1'b0, s_q} + {1'b0, tmp};
    acc_cur = acc[idx];
    acc_sum = {acc_cur[63], acc_cur} + {term[63], term};
    acc_ovf = acc_sum[64] != acc_sum[63];
  end

  // Drive unit requests from the sequencer state
  always_comb begin
    mul_req = '0;
    div_req = '0;
    case (state)
      ST_M1:   begin mul_req.a = km_q; mul_req.b = a;   end
      ST_SV:   begin mul_req.a = s_q;  mul_req.b = v_q; end
      ST_CC:   begin mul_req.a = c;    mul_req.b = c;   end
      ST_G1:   begin mul_req.a = t;    mul_req.b = a;   end
      ST_KR:   begin mul_req.a = km_q; mul_req.b = r;   end
      ST_G2:   begin mul_req.a = t;    mul_req.b = tmp; end
      ST_P:    begin mul_req.a = gi;   mul_req.b = gj;  end
      ST_W:    begin mul_req.a = p;    mul_req.b = {47'b0, weight}; end
      ST_R:    begin div_req.a = inh_q; div_req.b = kic_q; end
      ST_T:    begin div_req.a = tmp;   div_req.b = cc;    end
      ST_G0:   begin div_req.a = s_q;   div_req.b = c;     end
      ST_Q:    begin div_req.a = tmp;   div_req.b = kic_q; end
      default: ;
    endcase
    case (state)
      ST_M1, ST_SV, ST_CC, ST_G1, ST_KR, ST_G2, ST_P, ST_W: mul_req.start = !issued;
      ST_R, ST_T, ST_G0, ST_Q:                             div_req.start = !issued;
      default: ;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_velocity        <= 32'd65536;
      michaelis_constant  <= 32'd65536;
      inhibition_constant <= 32'd65536;
    end else if (cfg_write) begin
      case (cfg_index)
        cifa_pkg::REG_MAX_VELOCITY: max_velocity        <= cfg_data;
        cifa_pkg::REG_MICHAELIS:    michaelis_constant  <= cfg_data;
        cifa_pkg::REG_INHIBITION:   inhibition_constant <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      issued          <= 1'b0;
      hit             <= 1'b0;
      saturation_seen <= 1'b0;
      idx             <= 3'd0;
      info.valid      <= 1'b0;
      for (int k = 0; k < 6; k++) acc[k] <= 64'b0;
    end else begin
      if (emit) info.valid <= 1'b1;
      else if (info.ready) info.valid <= 1'b0;
      if (mul_req.start || div_req.start) issued <= 1'b1;
      case (state)
        ST_IDLE: begin
          if (point.valid) begin
            s_q        <= {16'b0, point.substrate, 16'b0};
            inh_q      <= {16'b0, point.inhibitor, 16'b0};
            weight     <= point.weight;
            last_point <= point.last_point;
            hit        <= 1'b0;
            state      <= ST_R;
          end
        end
        ST_R: if (div_done) begin
          r <= div_quot; hit <= hit | div_sat; issued <= 1'b0; state <= ST_A;
        end
        ST_A: begin
          a     <= sum_a[64] ? cifa_pkg::MAX_U64 : sum_a[63:0];
          hit   <= hit | sum_a[64];
          state <= ST_M1;
        end
        ST_M1: if (mul_done) begin
          tmp <= mulq_res; hit <= hit | mulq_sat; issued <= 1'b0; state <= ST_C;
        end
        ST_C: begin
          c   <= sum_c[64] ? cifa_pkg::MAX_U64 : sum_c[63:0];
          hit <= hit | sum_c[64];
          idx <= 3'd0;
          if (sum_c == 65'b0) begin
            // Zero denominator: the gradient is zero
            g0 <= 64'b0; g1 <= 64'b0; g2 <= 64'b0;
            state <= ST_P;
          end else begin
            state <= ST_SV;
          end
        end
        ST_SV: if (mul_done) begin
          tmp <= mulq_res; hit <= hit | mulq_sat; issued <= 1'b0; state <= ST_CC;
        end
        ST_CC: if (mul_done) begin
          cc <= mulq_res; hit <= hit | mulq_sat; issued <= 1'b0; state <= ST_T;
        end
        ST_T: if (div_done) begin
          t <= div_quot; hit <= hit | div_sat; issued <= 1'b0; state <= ST_G0;
        end
        ST_G0: if (div_done) begin
          g0 <= div_quot; hit <= hit | div_sat; issued <= 1'b0; state <= ST_G1;
        end
        ST_G1: if (mul_done) begin
          g1 <= mulq_res; hit <= hit | mulq_sat; issued <= 1'b0; state <= ST_KR;
        end
        ST_KR: if (mul_done) begin
          tmp <= mulq_res; hit <= hit | mulq_sat; issued <= 1'b0; state <= ST_Q;
        end
        ST_Q: if (div_done) begin
          tmp <= div_quot; hit <= hit | div_sat; issued <= 1'b0; state <= ST_G2;
        end
        ST_G2: if (mul_done) begin
          g2 <= mulq_res; hit <= hit | mulq_sat; issued <= 1'b0; state <= ST_P;
        end
        ST_P: if (mul_done) begin
          p <= mulq_res; hit <= hit | mulq_sat; issued <= 1'b0; state <= ST_W;
        end
        ST_W: if (mul_done) begin
          term   <= neg ? -term_mag : term_mag;
          hit    <= hit | term_sat;
          issued <= 1'b0;
          state  <= ST_ACC;
        end
        ST_ACC: begin
          // Add the term with saturation at the signed limits
          if (acc_ovf) begin
            acc[idx] <= term[63] ? cifa_pkg::MIN_S64 : cifa_pkg::MAX_S64;
            hit      <= 1'b1;
          end else begin
            acc[idx] <= acc_sum[63:0];
          end
          if (idx == 3'd5) begin
            state <= ST_DONE;
          end else begin
            idx   <= idx + 3'd1;
            state <= ST_P;
          end
        end
        ST_DONE: begin
          if (!last_point) begin
            saturation_seen <= saturation_seen | hit;
            state           <= ST_IDLE;
          end else if (!info.valid || info.ready) begin
            // Emit the matrix and clear
            info.entry_vv  <= acc[0];
            info.entry_vk  <= acc[1];
            info.entry_vi  <= acc[2];
            info.entry_kk  <= acc[3];
            info.entry_ki  <= acc[4];
            info.entry_ii  <= acc[5];
            info.saturated <= saturation_seen | hit;
            saturation_seen <= 1'b0;
            for (int k = 0; k < 6; k++) acc[k] <= 64'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Only one shared unit is started at a time
  assert property (@(posedge clk) disable iff (rst) !(mul_req.start && div_req.start))
    else $error("both units started together");

  // A new point is taken only after the sequencer is idle again
  assert property (@(posedge clk) disable iff (rst) (point.valid && point.ready) |=> !point.ready)
    else $error("ready stayed high after a point was taken");

  // Emitting a result clears the accumulators
  assert property (@(posedge clk) disable iff (rst)
    emit |=> (acc[0] == 64'b0 && acc[5] == 64'b0 && info.valid))
    else $error("accumulators not cleared on emit");

  // A unit result arrives only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst) (mul_done || div_done) |-> issued)
    else $error("unit result with no request outstanding");

endmodule

`default_nettype wire
